[rtl/core/tgwvs_pkg.sv]
// Shared types and constants for the two-gyro wheel velocity solver.
`timescale 1ns / 1ps
`default_nettype none
package tgwvs_pkg;

   localparam int WIDE_W = 192;
   localparam int CNT_W = 8;
   localparam int DIV_STEPS = 192;
   localparam int SQRT_STEPS = 96;

   typedef logic [WIDE_W-1:0] wide_type;
   typedef logic [WIDE_W:0] wide_ext_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_SQRT
   } alu_op_type;

   typedef struct packed {
      logic start;
      alu_op_type op;
      cnt_type steps;
   } alu_cmd_type;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WHEEL_RATIO = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WHEEL_RADIUS = 2'd1;

   localparam logic [15:0] WHEEL_RATIO_RESET = 16'd2202;
   localparam logic [15:0] WHEEL_RADIUS_RESET = 16'd5120;

endpackage
`default_nettype wire

[rtl/core/two_gyro_wheel_velocity_solver.sv]
// Two-gyro wheel velocity solver: sequencer, held rates, speed scaling, ports.
// One request at a time. A solved request runs 33 sequencer steps from acceptance to response
// through one shared 192-bit unit that multiplies one multiplier bit per cycle, divides one
// quotient bit per cycle (three divides) and takes square roots two radicand bits per cycle
// (two roots). A request with no solution stops at its failing step and answers sooner.
// The speeds then come from a 33x17 multiplier. The next request is taken while a response
// waits.
`timescale 1ns / 1ps
`default_nettype none
module two_gyro_wheel_velocity_solver (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [31:0]                     req_rate_right,
   input  wire logic signed [31:0]                     req_rate_left,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [31:0]                          rsp_omega_right,
   output logic signed [31:0]                          rsp_omega_left,
   output logic signed [31:0]                          rsp_omega_body,
   output logic signed [31:0]                          rsp_speed_right,
   output logic signed [31:0]                          rsp_speed_left,
   output logic signed [31:0]                          rsp_speed_body,
   output logic                                        rsp_solved,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [tgwvs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [15:0]                            csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_SPEED,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      DST_A,
      DST_B,
      DST_M,
      DST_T,
      DST_U,
      DST_E,
      DST_MA,
      DST_KS,
      DST_X,
      DST_Y,
      DST_Z
   } dst_type;

   localparam logic [5:0] LAST_STEP = 6'd32;

   state_type state_ff, state_in;
   logic [5:0] pc_ff, pc_in;
   logic [2:0] spd_cnt_ff, spd_cnt_in;
   logic solved_ff, solved_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [15:0] ratio_ff, ratio_in;
   logic [15:0] radius_ff, radius_in;
   logic signed [31:0] held_x_ff, held_x_in;
   logic signed [31:0] held_y_ff, held_y_in;
   logic signed [31:0] held_z_ff, held_z_in;

   logic [31:0] mag_r_ff, mag_r_in;
   logic [31:0] mag_l_ff, mag_l_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [31:0] m_ff, m_in;
   tgwvs_pkg::wide_type t_ff, t_in;
   tgwvs_pkg::wide_type u_ff, u_in;
   tgwvs_pkg::wide_type e_ff, e_in;
   tgwvs_pkg::wide_type ma_ff, ma_in;
   tgwvs_pkg::wide_type ks_ff, ks_in;
   tgwvs_pkg::wide_type x_ff, x_in;
   logic yneg_ff, yneg_in;
   logic signed [31:0] y_new_ff, y_new_in;
   logic signed [49:0] prod_ff, prod_in;
   logic signed [31:0] spd_r_ff, spd_r_in;
   logic signed [31:0] spd_l_ff, spd_l_in;
   logic signed [31:0] spd_b_ff, spd_b_in;
   logic signed [31:0] out_x_ff, out_x_in;
   logic signed [31:0] out_y_ff, out_y_in;
   logic signed [31:0] out_z_ff, out_z_in;
   logic signed [31:0] out_sr_ff, out_sr_in;
   logic signed [31:0] out_sl_ff, out_sl_in;
   logic signed [31:0] out_sb_ff, out_sb_in;
   logic out_solved_ff, out_solved_in;

   tgwvs_pkg::alu_op_type step_op;
   tgwvs_pkg::wide_type step_a;
   tgwvs_pkg::wide_type step_b;
   tgwvs_pkg::cnt_type step_n;
   dst_type step_dst;
   logic pre_fail;
   logic post_fail;

   tgwvs_pkg::alu_cmd_type alu_cmd;
   logic alu_done;
   tgwvs_pkg::wide_type alu_result;

   tgwvs_pkg::wide_type wa, wb, wm, wk, wr, wl, wone, abs_d, abs_e;
   logic signed [32:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [49:0] spd_shift;
   logic signed [31:0] spd_sat;
   logic req_fire;

   function automatic logic [31:0] sat32(input tgwvs_pkg::wide_type mag, input logic neg);
      logic big;
      big = |mag[tgwvs_pkg::WIDE_W-1:31];
      if (!neg) begin
         sat32 = big ? 32'h7FFF_FFFF : mag[31:0];
      end else begin
         sat32 = big ? 32'h8000_0000 : (32'd0 - mag[31:0]);
      end
   endfunction

   assign wa = tgwvs_pkg::wide_type'(a_ff);
   assign wb = tgwvs_pkg::wide_type'(b_ff);
   assign wm = tgwvs_pkg::wide_type'(m_ff);
   assign wk = tgwvs_pkg::wide_type'(ratio_ff);
   assign wr = tgwvs_pkg::wide_type'(mag_r_ff);
   assign wl = tgwvs_pkg::wide_type'(mag_l_ff);
   assign wone = tgwvs_pkg::wide_type'(1);
   assign abs_d = t_ff[tgwvs_pkg::WIDE_W-1] ? u_ff : t_ff;
   assign abs_e = e_ff[tgwvs_pkg::WIDE_W-1] ? t_ff : e_ff;

   // step program
   always_comb begin
      step_op = tgwvs_pkg::OP_ADD;
      step_a = '0;
      step_b = '0;
      step_n = '0;
      step_dst = DST_T;
      pre_fail = 1'b0;
      case (pc_ff)
         6'd0: begin
            step_op = tgwvs_pkg::OP_MUL; step_a = wr; step_b = wr; step_n = 8'd32;
            step_dst = DST_A; pre_fail = (ratio_ff == 16'd0);
         end
         6'd1: begin
            step_op = tgwvs_pkg::OP_MUL; step_a = wl; step_b = wl; step_n = 8'd32;
            step_dst = DST_B;
         end
         6'd2: begin
            step_op = tgwvs_pkg::OP_MUL; step_a = wk; step_b = wk; step_n = 8'd16;
            step_dst = DST_M;
         end
         6'd3: begin
            step_op = tgwvs_pkg::OP_ADD; step_a = wm; step_b = wone << 16; step_dst = DST_T;
         end
         6'd4: begin
            step_op = tgwvs_pkg::OP_MUL; step_a = wa; step_b = t_ff; step_n = 8'd33;
            step_dst = DST_T;
         end
         6'd5: begin
            step_op = tgwvs_pkg::OP_SUB; step_a = t_ff; step_b = wb << 16; step_dst = DST_E;
         end
         6'd6: begin
            step_op = tgwvs_pkg::OP_SUB; step_a = wa; step_b = wb; step_dst = DST_T;
         end
         6'd7: begin
            step_op = tgwvs_pkg::OP_SUB; step_a = '0; step_b = t_ff; step_dst = DST_U;
         end
         6'd8: begin
            step_op = tgwvs_pkg::OP_MUL; step_a = abs_d; step_b = abs_d; step_n = 8'd63;
            step_dst = DST_T;
         end
         6'd9: begin
            step_op = tgwvs_pkg::OP_MUL; step_a = wa; step_b = wm; step_n = 8'd32;
            step_dst = DST_MA;
         end
         6'd10: begin
            step_op = tgwvs_pkg::OP_MUL; step_a = ma_ff; step_b = wb; step_n = 8'd63;
            step_dst = DST_U;
         end
         6'd11: begin
            step_op = tgwvs_pkg::OP_SUB; step_a = u_ff; step_b = t_ff << 16; step_dst = DST_T;
         end
         6'd12: begin
            step_op = tgwvs_pkg::OP_SQRT; step_a = t_ff; step_dst = DST_T;
         end
         6'd13: begin
            step_op = tgwvs_pkg::OP_MUL; step_a = t_ff; step_b = wk; step_n = 8'd16;
            step_dst = DST_KS;
         end
         6'd14: begin
            step_op = tgwvs_pkg::OP_ADD; step_a = ma_ff; step_b = wa << 17; step_dst = DST_T;
         end
         6'd15: begin
            step_op = tgwvs_pkg::OP_ADD; step_a = t_ff; step_b = wa << 16; step_dst = DST_T;
         end
         6'd16: begin
            step_op = tgwvs_pkg::OP_SUB; step_a = t_ff; step_b = wb << 16; step_dst = DST_T;
         end
         6'd17: begin
            step_op = tgwvs_pkg::OP_MUL; step_a = t_ff; step_b = wm; step_n = 8'd32;
            step_dst = DST_U; pre_fail = t_ff[tgwvs_pkg::WIDE_W-1];
         end
         6'd18: begin
            step_op = tgwvs_pkg::OP_SUB; step_a = u_ff; step_b = ks_ff << 17; step_dst = DST_U;
         end
         6'd19: begin
            step_op = tgwvs_pkg::OP_ADD; step_a = wm; step_b = wone << 18; step_dst = DST_T;
         end
         6'd20: begin
            step_op = tgwvs_pkg::OP_MUL; step_a = t_ff; step_b = wm; step_n = 8'd32;
            step_dst = DST_T;
         end
         6'd21: begin
            step_op = tgwvs_pkg::OP_DIV; step_a = u_ff << 32; step_b = t_ff; step_dst = DST_T;
         end
         6'd22: begin
            step_op = tgwvs_pkg::OP_SQRT; step_a = t_ff; step_dst = DST_X;
         end
         6'd23: begin
            step_op = tgwvs_pkg::OP_SUB; step_a = wa << 16; step_b = wb << 16; step_dst = DST_T;
         end
         6'd24: begin
            step_op = tgwvs_pkg::OP_SUB; step_a = t_ff; step_b = ks_ff; step_dst = DST_T;
         end
         6'd25: begin
            step_op = tgwvs_pkg::OP_SUB; step_a = '0; step_b = t_ff; step_dst = DST_U;
         end
         6'd26: begin
            step_op = tgwvs_pkg::OP_MUL; step_a = abs_d; step_b = x_ff; step_n = 8'd80;
            step_dst = DST_U;
         end
         6'd27: begin
            step_op = tgwvs_pkg::OP_SUB; step_a = '0; step_b = e_ff; step_dst = DST_T;
         end
         6'd28: begin
            step_op = tgwvs_pkg::OP_DIV; step_a = u_ff; step_b = abs_e << 16; step_dst = DST_Y;
         end
         6'd29: begin
            step_op = tgwvs_pkg::OP_ADD; step_a = ma_ff; step_b = ks_ff; step_dst = DST_U;
         end
         6'd30: begin
            step_op = tgwvs_pkg::OP_MUL; step_a = u_ff; step_b = x_ff; step_n = 8'd80;
            step_dst = DST_U;
         end
         6'd31: begin
            step_op = tgwvs_pkg::OP_MUL; step_a = abs_e; step_b = wk << 8; step_n = 8'd24;
            step_dst = DST_T;
         end
         6'd32: begin
            step_op = tgwvs_pkg::OP_DIV; step_a = u_ff; step_b = t_ff; step_dst = DST_Z;
         end
         default: ;
      endcase
   end

   always_comb begin
      case (pc_ff)
         6'd5: post_fail = (alu_result == '0);
         6'd11, 6'd18: post_fail = alu_result[tgwvs_pkg::WIDE_W-1];
         default: post_fail = 1'b0;
      endcase
   end

   assign alu_cmd.start = (state_ff == ST_ISSUE) && !pre_fail;
   assign alu_cmd.op = step_op;
   assign alu_cmd.steps = step_n;

   tgwvs_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd),
      .opa    (step_a),
      .opb    (step_b),
      .done   (alu_done),
      .result (alu_result)
   );

   // speed multiplier
   always_comb begin
      case (spd_cnt_ff[2:1])
         2'd0: mul_a = 33'(held_x_ff);
         2'd1: mul_a = 33'(held_y_ff);
         default: mul_a = 33'(held_x_ff) + 33'(held_y_ff);
      endcase
   end
   assign mul_b = $signed({1'b0, radius_ff});
   assign prod_in = mul_a * mul_b;
   assign spd_shift = (spd_cnt_ff[2:1] == 2'd2) ? (prod_ff >>> 9) : (prod_ff >>> 8);
   assign spd_sat = (spd_shift[49:31] == {19{spd_shift[49]}}) ? spd_shift[31:0] :
                    (spd_shift[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      pc_in = pc_ff;
      spd_cnt_in = spd_cnt_ff;
      solved_in = solved_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ratio_in = ratio_ff;
      radius_in = radius_ff;
      held_x_in = held_x_ff;
      held_y_in = held_y_ff;
      held_z_in = held_z_ff;
      mag_r_in = mag_r_ff;
      mag_l_in = mag_l_ff;
      a_in = a_ff;
      b_in = b_ff;
      m_in = m_ff;
      t_in = t_ff;
      u_in = u_ff;
      e_in = e_ff;
      ma_in = ma_ff;
      ks_in = ks_ff;
      x_in = x_ff;
      yneg_in = yneg_ff;
      y_new_in = y_new_ff;
      spd_r_in = spd_r_ff;
      spd_l_in = spd_l_ff;
      spd_b_in = spd_b_ff;
      out_x_in = out_x_ff;
      out_y_in = out_y_ff;
      out_z_in = out_z_ff;
      out_sr_in = out_sr_ff;
      out_sl_in = out_sl_ff;
      out_sb_in = out_sb_ff;
      out_solved_in = out_solved_ff;

      if (csr_valid) begin
         unique case (csr_index)
            tgwvs_pkg::CSR_WHEEL_RATIO: ratio_in = csr_data;
            tgwvs_pkg::CSR_WHEEL_RADIUS: radius_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mag_r_in = req_rate_right[31] ? (32'd0 - req_rate_right) : req_rate_right;
               mag_l_in = req_rate_left[31] ? (32'd0 - req_rate_left) : req_rate_left;
               pc_in = '0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (pre_fail) begin
               solved_in = 1'b0;
               spd_cnt_in = '0;
               state_in = ST_SPEED;
            end else begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (alu_done) begin
               unique case (step_dst)
                  DST_A: a_in = alu_result[63:0];
                  DST_B: b_in = alu_result[63:0];
                  DST_M: m_in = alu_result[31:0];
                  DST_T: t_in = alu_result;
                  DST_U: u_in = alu_result;
                  DST_E: e_in = alu_result;
                  DST_MA: ma_in = alu_result;
                  DST_KS: ks_in = alu_result;
                  DST_X: x_in = alu_result;
                  DST_Y: y_new_in = sat32(alu_result, yneg_ff ^ e_ff[tgwvs_pkg::WIDE_W-1]);
                  DST_Z: begin
                     held_z_in = sat32(alu_result, e_ff[tgwvs_pkg::WIDE_W-1]);
                     held_y_in = y_new_ff;
                     held_x_in = sat32(x_ff >> 16, 1'b0);
                  end
                  default: ;
               endcase
               if (pc_ff == 6'd26) begin
                  yneg_in = t_ff[tgwvs_pkg::WIDE_W-1];
               end
               if (post_fail) begin
                  solved_in = 1'b0;
                  spd_cnt_in = '0;
                  state_in = ST_SPEED;
               end else if (pc_ff == LAST_STEP) begin
                  solved_in = 1'b1;
                  spd_cnt_in = '0;
                  state_in = ST_SPEED;
               end else begin
                  pc_in = pc_ff + 1'b1;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_SPEED: begin
            spd_cnt_in = spd_cnt_ff + 1'b1;
            if (spd_cnt_ff[0]) begin
               case (spd_cnt_ff[2:1])
                  2'd0: spd_r_in = spd_sat;
                  2'd1: spd_l_in = spd_sat;
                  default: spd_b_in = spd_sat;
               endcase
               if (spd_cnt_ff == 3'd5) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               out_x_in = held_x_ff;
               out_y_in = held_y_ff;
               out_z_in = held_z_ff;
               out_sr_in = spd_r_ff;
               out_sl_in = spd_l_ff;
               out_sb_in = spd_b_ff;
               out_solved_in = solved_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff <= '0;
         spd_cnt_ff <= '0;
         solved_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ratio_ff <= tgwvs_pkg::WHEEL_RATIO_RESET;
         radius_ff <= tgwvs_pkg::WHEEL_RADIUS_RESET;
         held_x_ff <= '0;
         held_y_ff <= '0;
         held_z_ff <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         spd_cnt_ff <= spd_cnt_in;
         solved_ff <= solved_in;
         rsp_valid_ff <= rsp_valid_in;
         ratio_ff <= ratio_in;
         radius_ff <= radius_in;
         held_x_ff <= held_x_in;
         held_y_ff <= held_y_in;
         held_z_ff <= held_z_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_r_ff <= mag_r_in;
      mag_l_ff <= mag_l_in;
      a_ff <= a_in;
      b_ff <= b_in;
      m_ff <= m_in;
      t_ff <= t_in;
      u_ff <= u_in;
      e_ff <= e_in;
      ma_ff <= ma_in;
      ks_ff <= ks_in;
      x_ff <= x_in;
      yneg_ff <= yneg_in;
      y_new_ff <= y_new_in;
      prod_ff <= prod_in;
      spd_r_ff <= spd_r_in;
      spd_l_ff <= spd_l_in;
      spd_b_ff <= spd_b_in;
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      out_z_ff <= out_z_in;
      out_sr_ff <= out_sr_in;
      out_sl_ff <= out_sl_in;
      out_sb_ff <= out_sb_in;
      out_solved_ff <= out_solved_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_omega_right = out_x_ff;
   assign rsp_omega_left = out_y_ff;
   assign rsp_omega_body = out_z_ff;
   assign rsp_speed_right = out_sr_ff;
   assign rsp_speed_left = out_sl_ff;
   assign rsp_speed_body = out_sb_ff;
   assign rsp_solved = out_solved_ff;

endmodule
`default_nettype wire

[rtl/core/tgwvs_alu.sv]
// Shared 192-bit iterative unit: add, subtract, shift-add multiply, restoring divide, square root.
`timescale 1ns / 1ps
`default_nettype none
module tgwvs_alu (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire tgwvs_pkg::alu_cmd_type cmd,
   input  wire tgwvs_pkg::wide_type    opa,
   input  wire tgwvs_pkg::wide_type    opb,
   output logic                        done,
   output tgwvs_pkg::wide_type         result
);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   tgwvs_pkg::alu_op_type op_ff, op_in;
   tgwvs_pkg::cnt_type cnt_ff, cnt_in;
   tgwvs_pkg::wide_type acc_ff, acc_in;
   tgwvs_pkg::wide_type aa_ff, aa_in;
   tgwvs_pkg::wide_type bb_ff, bb_in;
   tgwvs_pkg::wide_ext_type rem_ff, rem_in;

   tgwvs_pkg::wide_ext_type rem_shift;
   tgwvs_pkg::wide_ext_type rem_diff;
   tgwvs_pkg::wide_type sq_try;
   tgwvs_pkg::wide_ext_type sq_diff;

   assign rem_shift = {rem_ff[tgwvs_pkg::WIDE_W-1:0], aa_ff[tgwvs_pkg::WIDE_W-1]};
   assign rem_diff = rem_shift - {1'b0, bb_ff};
   assign sq_try = acc_ff + bb_ff;
   assign sq_diff = {1'b0, aa_ff} - {1'b0, sq_try};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in = op_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      aa_in = aa_ff;
      bb_in = bb_ff;
      rem_in = rem_ff;
      if (cmd.start) begin
         op_in = cmd.op;
         unique case (cmd.op)
            tgwvs_pkg::OP_ADD: begin
               acc_in = opa + opb;
               done_in = 1'b1;
            end
            tgwvs_pkg::OP_SUB: begin
               acc_in = opa - opb;
               done_in = 1'b1;
            end
            tgwvs_pkg::OP_MUL: begin
               acc_in = '0;
               aa_in = opa;
               bb_in = opb;
               cnt_in = cmd.steps;
               busy_in = 1'b1;
            end
            tgwvs_pkg::OP_DIV: begin
               acc_in = '0;
               aa_in = opa;
               bb_in = opb;
               rem_in = '0;
               cnt_in = tgwvs_pkg::CNT_W'(tgwvs_pkg::DIV_STEPS);
               busy_in = 1'b1;
            end
            tgwvs_pkg::OP_SQRT: begin
               acc_in = '0;
               aa_in = opa;
               bb_in = {2'b01, {(tgwvs_pkg::WIDE_W-2){1'b0}}};
               cnt_in = tgwvs_pkg::CNT_W'(tgwvs_pkg::SQRT_STEPS);
               busy_in = 1'b1;
            end
            default: ;
         endcase
      end else if (busy_ff) begin
         unique case (op_ff)
            tgwvs_pkg::OP_MUL: begin
               if (bb_ff[0]) begin
                  acc_in = acc_ff + aa_ff;
               end
               aa_in = aa_ff << 1;
               bb_in = bb_ff >> 1;
            end
            tgwvs_pkg::OP_DIV: begin
               if (!rem_diff[tgwvs_pkg::WIDE_W]) begin
                  rem_in = rem_diff;
                  acc_in = {acc_ff[tgwvs_pkg::WIDE_W-2:0], 1'b1};
               end else begin
                  rem_in = rem_shift;
                  acc_in = {acc_ff[tgwvs_pkg::WIDE_W-2:0], 1'b0};
               end
               aa_in = aa_ff << 1;
            end
            tgwvs_pkg::OP_SQRT: begin
               if (!sq_diff[tgwvs_pkg::WIDE_W]) begin
                  aa_in = sq_diff[tgwvs_pkg::WIDE_W-1:0];
                  acc_in = (acc_ff >> 1) + bb_ff;
               end else begin
                  acc_in = acc_ff >> 1;
               end
               bb_in = bb_ff >> 2;
            end
            default: ;
         endcase
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == tgwvs_pkg::cnt_type'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff <= tgwvs_pkg::OP_ADD;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff <= op_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      aa_ff <= aa_in;
      bb_ff <= bb_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign result = acc_ff;

endmodule
`default_nettype wire
